[hw/rtl/spbtp_pkg.sv]
// ----------------------------------------------------------------------------
// spbtp_pkg
// Shared types and constants of the spectral band top peaks block.
// ----------------------------------------------------------------------------
package spbtp_pkg;

  localparam int BIN_W   = 10;
  localparam int SAMP_W  = 24;
  localparam int POWER_W = 48;
  localparam int RATE_W  = 18;
  localparam int COUNT_W = 4;
  localparam int WIN_W   = 16;
  localparam int FREQ_W  = 17;
  localparam int RANK_W  = 3;
  localparam int CFG_W   = 18;
  localparam int CFGI_W  = 2;

  localparam logic [CFGI_W-1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [CFGI_W-1:0] REG_PEAK_CNT  = 2'd2;
  localparam logic [CFGI_W-1:0] REG_RATE      = 2'd3;

  typedef enum logic {
    S_FILL,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [POWER_W-1:0] power;
    logic [BIN_W-1:0]   bin;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               inband;
    logic [POWER_W-1:0] power;
    logic [BIN_W-1:0]   bin;
  } item_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[hw/rtl/spectral_band_top_peaks.sv]
// ----------------------------------------------------------------------------
// spectral_band_top_peaks
// Keeps the strongest in-band FFT bins of a window and emits them per window.
// ----------------------------------------------------------------------------
// Bins are taken one per cycle for the whole window; each bin passes a
// two-stage squaring pipeline and is then sorted into a row of MAX_PEAKS
// cells. Once the last bin of a window is taken, s_tready stays low until
// the list is drained: the pipeline empties, the peaks are emitted one at
// a time (held while m_tready stalls), and then the list is cleared and
// the window counter steps. FFT_SIZE must be a power of two.
module spectral_band_top_peaks #(
  parameter int FFT_SIZE  = 1024,
  parameter int MAX_PEAKS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // bin_re, bin_im, bin_index
  input  logic                          s_tlast,   // last_bin
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // window_number, peak_bin,
                                                   // peak_freq_hz, peak_rank
  output logic                          m_tlast,   // last_peak
  input  logic                          cfg_we,
  input  logic [spbtp_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [spbtp_pkg::CFG_W-1:0]   cfg_data
);
  import spbtp_pkg::*;

  localparam int LOG2_FFT = $clog2(FFT_SIZE);
  localparam int CAP      = (MAX_PEAKS < 8) ? MAX_PEAKS : 8;
  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);
  localparam int PROD_W   = BIN_W + RATE_W;

  logic [BIN_W-1:0]   band_low;
  logic [BIN_W-1:0]   band_high;
  logic [COUNT_W-1:0] peak_count;
  logic [RATE_W-1:0]  rate_cfg;

  state_t             state;
  state_t             state_next;
  logic               last_pending;
  logic [COUNT_W-1:0] remaining;
  logic [RANK_W-1:0]  rank;
  logic [WIN_W-1:0]   window;

  item_t              item;
  cell_ctrl_t         ctrl;
  logic               drain_done;
  logic               emit;
  logic [COUNT_W-1:0] emit_cnt;

  entry_t             entries   [MAX_PEAKS];
  entry_t             prev_e    [MAX_PEAKS];
  entry_t             next_e    [MAX_PEAKS];
  logic               above     [MAX_PEAKS];
  logic               prev_ab   [MAX_PEAKS];
  logic [MAX_PEAKS-1:0] valid_vec;

  logic [PROD_W-1:0]  freq_prod;
  logic [PROD_W-1:0]  freq_shift;

  logic [WIN_W-1:0]   out_window;
  logic [BIN_W-1:0]   out_bin;
  logic [FREQ_W-1:0]  out_freq;
  logic [RANK_W-1:0]  out_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low    <= BIN_W'(7);
      band_high   <= BIN_W'(69);
      peak_count  <= COUNT_W'(5);
      rate_cfg    <= RATE_W'(44100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND_LOW:  band_low    <= cfg_data[BIN_W-1:0];
        REG_BAND_HIGH: band_high   <= cfg_data[BIN_W-1:0];
        REG_PEAK_CNT:  peak_count  <= cfg_data[COUNT_W-1:0];
        REG_RATE:      rate_cfg    <= cfg_data[RATE_W-1:0];
      endcase
    end
  end

  assign s_tready = !last_pending;

  spbtp_power u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && s_tready),
    .re        ($signed(s_tdata[SAMP_W-1:0])),
    .im        ($signed(s_tdata[2*SAMP_W-1:SAMP_W])),
    .bin       (s_tdata[2*SAMP_W+BIN_W-1:2*SAMP_W]),
    .last      (s_tlast),
    .band_low  (band_low),
    .band_high (band_high),
    .item      (item)
  );

  for (genvar k = 0; k < MAX_PEAKS; k++) begin : g_cell
    always_comb begin
      if (k == 0) begin
        prev_e[k]       = '0;
        prev_ab[k]      = 1'b0;
      end else begin
        prev_e[k]       = entries[(k == 0) ? 0 : k-1];
        prev_ab[k]      = above[(k == 0) ? 0 : k-1];
      end
      if (k == MAX_PEAKS-1) begin
        next_e[k]       = '0;
      end else begin
        next_e[k]       = entries[(k == MAX_PEAKS-1) ? k : k+1];
      end
    end

    assign valid_vec[k] = entries[k].valid;

    spbtp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_power  (item.power),
      .new_bin    (item.bin),
      .prev_entry (prev_e[k]),
      .prev_above (prev_ab[k]),
      .next_entry (next_e[k]),
      .entry      (entries[k]),
      .above      (above[k])
    );
  end

  assign emit_cnt   = (peak_count < CAP_CNT) ? peak_count : CAP_CNT;
  assign drain_done = (state == S_DRAIN) && ((remaining == '0) || !entries[0].valid);

  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL:  if (item.valid && item.last) state_next = S_DRAIN;
      S_DRAIN: if (drain_done) state_next = S_FILL;
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    ctrl        = '0;
    unique case (state)
      S_FILL: begin
        ctrl.insert = item.valid && item.inband;
      end
      S_DRAIN: begin
        emit       = !drain_done && (!m_tvalid || m_tready);
        ctrl.shift = emit;
        ctrl.clear = drain_done;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      last_pending <= 1'b0;
      remaining    <= '0;
      rank         <= '0;
      window       <= '0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready && s_tlast) begin
        last_pending <= 1'b1;
      end else if (drain_done) begin
        last_pending <= 1'b0;
      end
      if (state == S_FILL) begin
        remaining <= emit_cnt;
        rank      <= '0;
      end else if (emit) begin
        remaining <= remaining - COUNT_W'(1);
        rank      <= rank + RANK_W'(1);
      end
      if (drain_done) begin
        window <= window + WIN_W'(1);
      end
    end
  end

  assign freq_prod  = PROD_W'(entries[0].bin) * PROD_W'(rate_cfg);
  assign freq_shift = freq_prod >> LOG2_FFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      out_window <= window;
      out_bin    <= entries[0].bin;
      out_freq   <= freq_shift[FREQ_W-1:0];
      out_rank   <= rank;
      m_tlast    <= (remaining == COUNT_W'(1)) || !next_e[0].valid;
    end
  end

  assign m_tdata = {2'b00, out_rank, out_freq, out_bin, out_window};

  a_ready_only_fill: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_FILL))
    else $error("input ready outside of fill state");

  a_no_emit_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |=> !$rose(m_tvalid) || ($past(state) == S_DRAIN))
    else $error("result produced while filling");

  a_cells_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + MAX_PEAKS'(1))) == '0)
    else $error("peak list has a gap");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> (valid_vec == '0) && !last_pending)
    else $error("list not cleared after drain");

endmodule

[hw/rtl/spbtp_power.sv]
// ----------------------------------------------------------------------------
// spbtp_power
// Two-stage squared magnitude pipeline with the band test.
// ----------------------------------------------------------------------------
module spbtp_power (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [spbtp_pkg::SAMP_W-1:0] re,
  input  logic signed [spbtp_pkg::SAMP_W-1:0] im,
  input  logic [spbtp_pkg::BIN_W-1:0]     bin,
  input  logic                            last,
  input  logic [spbtp_pkg::BIN_W-1:0]     band_low,
  input  logic [spbtp_pkg::BIN_W-1:0]     band_high,
  output spbtp_pkg::item_t                item
);
  import spbtp_pkg::*;

  logic                      valid1;
  logic                      last1;
  logic                      inband1;
  logic [BIN_W-1:0]          bin1;
  logic signed [POWER_W-1:0] sq_re;
  logic signed [POWER_W-1:0] sq_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    last1   <= last;
    bin1    <= bin;
    inband1 <= (bin >= band_low) && (bin <= band_high);
    sq_re   <= re * re;
    sq_im   <= im * im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= valid1;
    end
    item.last   <= last1;
    item.inband <= inband1;
    item.bin    <= bin1;
    item.power  <= POWER_W'($unsigned(sq_re) + $unsigned(sq_im));
  end

endmodule

[hw/rtl/spbtp_cell.sv]
// ----------------------------------------------------------------------------
// spbtp_cell
// One slot of the sorted peak list: compares, inserts and shifts.
// ----------------------------------------------------------------------------
module spbtp_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  spbtp_pkg::cell_ctrl_t        ctrl,
  input  logic [spbtp_pkg::POWER_W-1:0] new_power,
  input  logic [spbtp_pkg::BIN_W-1:0]  new_bin,
  input  spbtp_pkg::entry_t            prev_entry,
  input  logic                         prev_above,
  input  spbtp_pkg::entry_t            next_entry,
  output spbtp_pkg::entry_t            entry,
  output logic                         above
);
  import spbtp_pkg::*;

  entry_t entry_next;

  assign above = !entry.valid || (new_power > entry.power) ||
                 ((new_power == entry.power) && (new_bin < entry.bin));

  always_comb begin
    entry_next = entry;
    priority if (ctrl.clear) begin
      entry_next.valid = 1'b0;
    end else if (ctrl.shift) begin
      entry_next = next_entry;
    end else if (ctrl.insert && above) begin
      if (prev_above) begin
        entry_next = prev_entry;
      end else begin
        entry_next.valid = 1'b1;
        entry_next.power = new_power;
        entry_next.bin   = new_bin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.power <= entry_next.power;
    entry.bin   <= entry_next.bin;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the spectral band top peaks block.
// ----------------------------------------------------------------------------
// A queue of FFT bins feeds a bursty stream driver, and a predictor ranks
// every accepted in-band bin the way the block should. On the last bin of
// a window the predictor queues the expected peaks, and a monitor with its
// own back-pressure pattern compares every output transaction against
// them, field by field. A directed part covers the band edges, ties,
// repeated bins and register extremes. A random part follows.
// ----------------------------------------------------------------------------
module tb;
  import spbtp_pkg::*;

  localparam int FFT_N      = 1024;
  localparam int LIST_DEPTH = 8;
  localparam int SETTLE_CYC = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 450;
  localparam int MAX_ERR_LOG = 40;

  typedef struct packed {
    logic [SAMP_W-1:0] re;
    logic [SAMP_W-1:0] im;
    logic [BIN_W-1:0]  idx;
    logic              last;
  } fft_bin_t;

  typedef struct packed {
    logic [WIN_W-1:0]  win;
    logic [BIN_W-1:0]  bin;
    logic [FREQ_W-1:0] freq;
    logic [RANK_W-1:0] rank;
    logic              last;
  } peak_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;
  logic              m_tlast;
  logic              cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = REG_BAND_LOW;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic [BIN_W-1:0]   low_bin = 10'd7;
  logic [BIN_W-1:0]   high_bin = 10'd69;
  logic [COUNT_W-1:0] emit_cfg = 4'd5;
  logic [RATE_W-1:0]  rate_hz = 18'd44100;
  logic [POWER_W-1:0] kept_pow [LIST_DEPTH];
  logic [BIN_W-1:0]   kept_bin [LIST_DEPTH];
  int                 n_kept = 0;
  logic [WIN_W-1:0]   win_cnt = '0;

  fft_bin_t bin_q[$];
  peak_t    peak_q[$];
  fft_bin_t cur_bin;

  int n_in = 0;
  int n_out = 0;
  int n_err = 0;
  int n_cfg = 0;
  int n_win_sent = 0;
  int n_rand = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_cyc = 0;
  int stall_mode = 0;
  int idle_cnt = 0;

  spectral_band_top_peaks u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void insert_peak(input logic [POWER_W-1:0] pw,
                                      input logic [BIN_W-1:0] b);
    int pos;
    int k;
    pos = 0;
    while (pos < n_kept &&
           !(pw > kept_pow[pos] || (pw == kept_pow[pos] && b < kept_bin[pos])))
      pos++;
    if (pos < LIST_DEPTH) begin
      if (n_kept < LIST_DEPTH) n_kept++;
      for (k = n_kept - 1; k > pos; k--) begin
        kept_pow[k] = kept_pow[k-1];
        kept_bin[k] = kept_bin[k-1];
      end
      kept_pow[pos] = pw;
      kept_bin[pos] = b;
    end
  endfunction

  function automatic void take_bin(input fft_bin_t it);
    logic signed [POWER_W-1:0] re_w;
    logic signed [POWER_W-1:0] im_w;
    logic [POWER_W-1:0]        pw;
    logic [31:0]               prod;
    int                        emit;
    int                        k;
    peak_t                     pk;
    re_w = $signed(it.re);
    im_w = $signed(it.im);
    pw = re_w * re_w + im_w * im_w;
    if (it.idx >= low_bin && it.idx <= high_bin) insert_peak(pw, it.idx);
    if (it.last) begin
      emit = (emit_cfg > LIST_DEPTH) ? LIST_DEPTH : int'(emit_cfg);
      if (emit > n_kept) emit = n_kept;
      for (k = 0; k < emit; k++) begin
        prod = 32'(kept_bin[k]) * 32'(rate_hz);
        pk.win = win_cnt;
        pk.bin = kept_bin[k];
        pk.freq = FREQ_W'(prod / FFT_N);
        pk.rank = RANK_W'(k);
        pk.last = (k == emit - 1);
        peak_q = {peak_q, pk};
      end
      n_kept = 0;
      win_cnt = win_cnt + 1'b1;
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_err++;
      if (n_err <= MAX_ERR_LOG)
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  function automatic void check_peak();
    peak_t pk;
    if (peak_q.size() == 0) begin
      n_err++;
      if (n_err <= MAX_ERR_LOG)
        $error("peak transaction with no expected peak: tdata %h", m_tdata);
    end else begin
      pk = peak_q.pop_front();
      cmp_field("window_number", pk.win, m_tdata[15:0]);
      cmp_field("peak_bin", pk.bin, m_tdata[25:16]);
      cmp_field("peak_freq_hz", pk.freq, m_tdata[42:26]);
      cmp_field("peak_rank", pk.rank, m_tdata[45:43]);
      cmp_field("last_peak", pk.last, m_tlast);
    end
    n_out++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_bin(cur_bin);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (bin_q.size() > 0) begin
          cur_bin = bin_q.pop_front();
          s_tdata <= {6'b0, cur_bin.idx, cur_bin.im, cur_bin.re};
          s_tlast <= cur_bin.last;
          s_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_peak();
      stall_cyc++;
      if (stall_cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (stall_cyc % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic logic [SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return '0;
      3: return SAMP_W'($urandom_range(0, 2) << 12);
      4: return SAMP_W'(-($urandom_range(0, 2) << 12));
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  task automatic push_bin(input int idx, input logic [SAMP_W-1:0] re,
                          input logic [SAMP_W-1:0] im, input bit last);
    fft_bin_t it;
    it.re = re;
    it.im = im;
    it.idx = BIN_W'(idx);
    it.last = last;
    bin_q = {bin_q, it};
    if (last) n_win_sent++;
    n_rand++;
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      REG_BAND_LOW:  low_bin = BIN_W'(val);
      REG_BAND_HIGH: high_bin = BIN_W'(val);
      REG_PEAK_CNT:  emit_cfg = COUNT_W'(val);
      default:       rate_hz = RATE_W'(val);
    endcase
    n_cfg++;
  endtask

  task automatic write_config(input int unsigned lo, input int unsigned hi,
                              input int unsigned cnt, input int unsigned rate);
    write_reg(REG_BAND_LOW, lo);
    write_reg(REG_BAND_HIGH, hi);
    write_reg(REG_PEAK_CNT, cnt);
    write_reg(REG_RATE, rate);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (bin_q.size() > 0 || s_tvalid || peak_q.size() > 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic rand_config();
    int unsigned lo, hi, cnt, rate;
    case ($urandom_range(0, 5))
      0: begin lo = 0; hi = 1023; end
      1: begin lo = $urandom_range(0, 1023); hi = $urandom_range(0, lo); end
      2: begin lo = $urandom_range(0, 512); hi = lo; end
      default: begin lo = $urandom_range(0, 512); hi = lo + $urandom_range(0, 200); end
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 0;
      1: cnt = $urandom_range(9, 15);
      default: cnt = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 7))
      0: rate = 0;
      1: rate = 262143;
      2: rate = 196000;
      3: rate = 44100;
      4: rate = 1;
      default: rate = $urandom_range(1, 196000);
    endcase
    write_config(lo, hi, cnt, rate);
  endtask

  task automatic rand_window();
    int len, start, idx, i;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
    start = int'(low_bin) - 2 + $urandom_range(0, 6);
    if (start < 0) start = 0;
    idx = start;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: idx = $urandom_range(0, 1023);
        1: idx = idx;
        default: idx = (start + i) % 1024;
      endcase
      push_bin(idx, rand_sample(), rand_sample(), i == len - 1);
    end
  endtask

  initial begin
    int nw;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_bin(6, 24'h7FFFFF, 24'h7FFFFF, 0);
    push_bin(70, 24'h800000, 24'h800000, 0);
    push_bin(7, 24'h7FFFFF, 24'h000000, 0);
    push_bin(69, 24'h000000, 24'h800000, 0);
    push_bin(20, 24'h003000, 24'h000000, 0);
    push_bin(10, 24'hFFD000, 24'h000000, 0);
    push_bin(30, 24'h000000, 24'h002000, 0);
    push_bin(30, 24'h000000, 24'h002000, 0);
    push_bin(40, 24'h000000, 24'h000000, 0);
    push_bin(50, 24'h800000, 24'h800000, 0);
    push_bin(60, 24'h000003, 24'h000004, 1);
    push_bin(0, 24'h7FFFFF, 24'h000000, 1);
    wait_idle();

    write_config(100, 50, 8, 44100);
    push_bin(75, 24'h001000, 24'h001000, 1);
    wait_idle();

    write_config(0, 1023, 15, 0);
    push_bin(0, rand_sample(), rand_sample(), 0);
    push_bin(1023, rand_sample(), rand_sample(), 0);
    push_bin(512, rand_sample(), rand_sample(), 0);
    push_bin(300, rand_sample(), rand_sample(), 0);
    push_bin(1, 24'h000100, 24'h000100, 0);
    push_bin(1, 24'h000100, 24'h000100, 0);
    push_bin(2, rand_sample(), rand_sample(), 0);
    push_bin(3, rand_sample(), rand_sample(), 0);
    push_bin(4, rand_sample(), rand_sample(), 1);
    wait_idle();

    write_config(512, 1023, 0, 262143);
    push_bin(1023, 24'h7FFFFF, 24'h7FFFFF, 1);
    wait_idle();

    write_config(512, 1023, 8, 262143);
    push_bin(1023, 24'h000100, 24'h000000, 0);
    push_bin(512, 24'h000100, 24'h000000, 0);
    push_bin(513, 24'h800000, 24'h7FFFFF, 0);
    push_bin(511, 24'h7FFFFF, 24'h7FFFFF, 1);
    wait_idle();

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      rand_config();
      nw = $urandom_range(1, 4);
      repeat (nw) begin
        rand_window();
        if ($urandom_range(0, 2) == 0) wait_idle();
      end
      wait_idle();
    end

    $display("Run covered %0d bin transactions in %0d windows, %0d peaks checked.",
             n_in, n_win_sent, n_out);
    $display("Registers written %0d times, band and count extremes included.",
             n_cfg);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[spectral_band_top_peaks.f]
hw/rtl/spbtp_pkg.sv
hw/rtl/spbtp_power.sv
hw/rtl/spbtp_cell.sv
hw/rtl/spectral_band_top_peaks.sv
tb/tb.sv
